FILE: rtl/base64_stream_encoder_defines.svh
// Assertion helpers shared by the encoder modules.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef BASE64_STREAM_ENCODER_DEFINES_SVH
`define BASE64_STREAM_ENCODER_DEFINES_SVH

// A property that must hold at every clock edge outside reset.
`define B64S_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// A condition in one cycle that implies a result in the next cycle.
`define B64S_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/b64s_pkg.sv
package b64s_pkg;

  // Work queue between the front and back halves.
  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);
  localparam int QCW    = $clog2(QDEPTH + 1);

  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_DIGIT_0 = 8'h30;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_SLASH   = 8'h2F;
  localparam logic [7:0] CH_PAD     = 8'h3D;

  // Position of the next byte inside its three-byte group.
  typedef enum logic [2:0] {
    PH0 = 3'b001,
    PH1 = 3'b010,
    PH2 = 3'b100
  } phase_t;

  // One unit of work: the six-bit codes a byte completes, how many of them
  // are real, how many pad characters follow, and whether it ends the message.
  typedef struct packed {
    logic [5:0] sx0;
    logic [5:0] sx1;
    logic       two_sym;
    logic [1:0] n_pad;
    logic       fin;
  } job_t;

  function automatic logic [7:0] b64_char(input logic [5:0] six);
    logic [7:0] v;
    logic [7:0] ch;
    v = {2'b00, six};
    case (six) inside
      [6'd0:6'd25]:  ch = CH_UPPER_A + v;
      [6'd26:6'd51]: ch = CH_LOWER_A + (v - 8'd26);
      [6'd52:6'd61]: ch = CH_DIGIT_0 + (v - 8'd52);
      6'd62:         ch = CH_PLUS;
      default:       ch = CH_SLASH;
    endcase
    return ch;
  endfunction

endpackage

FILE: rtl/b64s_front.sv
`include "base64_stream_encoder_defines.svh"

module b64s_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [7:0]        in_data,
  input  logic              in_final,
  input  logic              q_ready,
  output logic              q_push,
  output b64s_pkg::job_t    q_job
);
  import b64s_pkg::*;

  phase_t     phase_r, phase_nxt;
  logic [3:0] carry_r, carry_nxt;
  job_t       job;

  assign in_tready = q_ready;
  assign q_push    = in_tvalid && q_ready;
  assign q_job     = job;

  always_comb begin
    job       = '0;
    job.fin   = in_final;
    phase_nxt = phase_r;
    carry_nxt = carry_r;
    case (phase_r)
      PH1: begin
        job.sx0 = {carry_r[1:0], in_data[7:4]};
        job.sx1 = {in_data[3:0], 2'b00};
        if (in_final) begin
          job.two_sym = 1'b1;
          job.n_pad   = 2'd1;
          phase_nxt   = PH0;
          carry_nxt   = '0;
        end else begin
          phase_nxt = PH2;
          carry_nxt = in_data[3:0];
        end
      end
      PH2: begin
        job.sx0     = {carry_r, in_data[7:6]};
        job.sx1     = in_data[5:0];
        job.two_sym = 1'b1;
        phase_nxt   = PH0;
        carry_nxt   = '0;
      end
      default: begin
        job.sx0 = in_data[7:2];
        job.sx1 = {in_data[1:0], 4'b0000};
        if (in_final) begin
          job.two_sym = 1'b1;
          job.n_pad   = 2'd2;
          phase_nxt   = PH0;
          carry_nxt   = '0;
        end else begin
          phase_nxt = PH1;
          carry_nxt = {2'b00, in_data[1:0]};
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH0;
      carry_r <= '0;
    end else if (q_push) begin
      phase_r <= phase_nxt;
      carry_r <= carry_nxt;
    end
  end

  `B64S_ASSERT_NEXT(a_final_restarts, q_push && in_final, phase_r == PH0 && carry_r == 4'd0, "final byte did not restart the group")

endmodule

FILE: rtl/b64s_queue.sv
`include "base64_stream_encoder_defines.svh"

module b64s_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  output logic              ready,
  input  b64s_pkg::job_t    push_job,
  input  logic              pop,
  output logic              valid,
  output b64s_pkg::job_t    pop_job
);
  import b64s_pkg::*;

  job_t             mem_r [QDEPTH];
  logic [QAW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [QCW-1:0]   cnt_r;
  logic             do_push, do_pop;

  assign ready   = (cnt_r != QCW'(QDEPTH));
  assign valid   = (cnt_r != '0);
  assign pop_job = mem_r[rd_ptr_r];
  assign do_push = push && ready;
  assign do_pop  = pop && valid;

  function automatic logic [QAW-1:0] ptr_inc(input logic [QAW-1:0] p);
    return (p == QAW'(QDEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= ptr_inc(wr_ptr_r);
      end
      if (do_pop) begin
        rd_ptr_r <= ptr_inc(rd_ptr_r);
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  `B64S_ASSERT(a_cnt_bound, cnt_r <= QCW'(QDEPTH), "queue count beyond depth")
  `B64S_ASSERT(a_no_overflow, !(push && !ready), "push into a full queue")

endmodule

FILE: rtl/b64s_back.sv
`include "base64_stream_encoder_defines.svh"

module b64s_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_valid,
  input  b64s_pkg::job_t    q_job,
  output logic              q_pop,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [7:0]        out_char,
  output logic              out_last
);
  import b64s_pkg::*;

  job_t       job_r, job_nxt;
  logic       busy_r, busy_nxt;
  logic [1:0] idx_r, idx_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic [7:0] out_char_r, out_char_nxt;
  logic       out_last_r, out_last_nxt;

  logic       out_free, emit, at_end;
  logic [2:0] total;
  logic [7:0] cur_char;

  assign out_free = !out_valid_r || out_tready;
  assign emit     = busy_r && out_free;
  assign total    = 3'd1 + {2'b00, job_r.two_sym} + {1'b0, job_r.n_pad};
  assign at_end   = ({1'b0, idx_r} == total - 3'd1);
  assign q_pop    = q_valid && (!busy_r || (emit && at_end));

  always_comb begin
    if (idx_r == 2'd0) begin
      cur_char = b64_char(job_r.sx0);
    end else if (idx_r == 2'd1 && job_r.two_sym) begin
      cur_char = b64_char(job_r.sx1);
    end else begin
      cur_char = CH_PAD;
    end
  end

  always_comb begin
    job_nxt       = job_r;
    busy_nxt      = busy_r;
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
      out_char_nxt  = cur_char;
      out_last_nxt  = job_r.fin && at_end;
      idx_nxt       = idx_r + 1'b1;
      if (at_end) begin
        busy_nxt = 1'b0;
      end
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (q_pop) begin
      job_nxt  = q_job;
      busy_nxt = 1'b1;
      idx_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    job_r      <= job_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_char   = out_char_r;
  assign out_last   = out_last_r;

  `B64S_ASSERT(a_idx_in_job, !busy_r || ({1'b0, idx_r} < total), "character index past end of job")
  `B64S_ASSERT_NEXT(a_last_marked, emit && at_end && job_r.fin, out_valid_r && out_last_r, "message end not flagged on output")

endmodule

FILE: rtl/base64_stream_encoder.sv
// Channel | Direction | tdata (low bit up)   | tlast        | Notes
// in_     | input     | [7:0] data_byte      | final_byte   | one raw byte per item
// out_    | output    | [7:0] out_char       | out_last     | one ASCII character per item
//
// The output runs at one character per cycle while out_tready is high; a byte yields one or two
// characters, and a final byte up to four, so the output port sets the sustained rate.
// A byte that finds the path empty passes through a queue entry, the back half's job register
// and its output register before its first character shows on the output.
// Reset is synchronous and active low; it returns the encoder to the start of a group.
// A four-entry work queue lets the input keep taking bytes while the output stalls.

module base64_stream_encoder (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] data_byte
  input  logic       in_tlast,   // final_byte
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] out_char
  output logic       out_tlast   // out_last
);
  import b64s_pkg::*;

  // The front half tracks the group position and the leftover bits of the
  // previous byte, and turns each accepted byte into a job: the six-bit codes
  // it completes plus the number of pad characters owed at the message end.
  logic q_ready, q_push, q_valid, q_pop;
  job_t push_job, pop_job;

  b64s_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_data   (in_tdata),
    .in_final  (in_tlast),
    .q_ready   (q_ready),
    .q_push    (q_push),
    .q_job     (push_job)
  );

  // Jobs wait here so that a stalled output never blocks the input directly.
  b64s_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .ready    (q_ready),
    .push_job (push_job),
    .pop      (q_pop),
    .valid    (q_valid),
    .pop_job  (pop_job)
  );

  // The back half maps codes to the alphabet and plays each job out one
  // character at a time through a registered output stage. It loads the next job, if the queue
  // holds one, in the same cycle it sends the last character of the current one.
  b64s_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_job      (pop_job),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_char   (out_tdata),
    .out_last   (out_tlast)
  );

endmodule

FILE: test/base64_stream_encoder_tb.sv
`timescale 1ns / 100ps

module base64_stream_encoder_tb;
  import b64s_pkg::*;

  localparam int CLK_HALF    = 5;
  localparam int RESET_CYC   = 7;
  localparam int DRAIN_CYC   = 8;
  localparam int CYCLE_LIMIT = 60000;
  localparam int RANDOM_BYTES = 105;

  // Expected-character store and the encoder predictor.
  class b64_char_scoreboard;
    typedef struct packed {
      logic [7:0] ch;
      logic       last;
    } enc_char_t;

    string      alphabet = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
    enc_char_t  expected_chars[$];
    phase_t     phase;
    logic [3:0] carry;
    int         errors;
    int         chars_checked;
    int         bytes_seen;
    int         messages_seen;

    function new();
      phase         = PH0;
      carry         = 4'h0;
      errors        = 0;
      chars_checked = 0;
      bytes_seen    = 0;
      messages_seen = 0;
    endfunction

    function logic [7:0] sym(logic [5:0] six);
      return alphabet[six];
    endfunction

    function void push_char(logic [7:0] ch, logic last);
      enc_char_t e;
      e.ch   = ch;
      e.last = last;
      expected_chars = {expected_chars, e};
    endfunction

    // Predicts the characters one accepted byte releases.
    function void note_byte(logic [7:0] b, logic fin);
      bytes_seen++;
      if (fin) messages_seen++;
      case (phase)
        PH1: begin
          push_char(sym({carry[1:0], b[7:4]}), 1'b0);
          if (fin) begin
            push_char(sym({b[3:0], 2'b00}), 1'b0);
            push_char(CH_PAD, 1'b1);
            phase = PH0;
            carry = 4'h0;
          end else begin
            carry = b[3:0];
            phase = PH2;
          end
        end
        PH2: begin
          // The third byte always closes the group, final or not.
          push_char(sym({carry, b[7:6]}), 1'b0);
          push_char(sym(b[5:0]), fin);
          phase = PH0;
          carry = 4'h0;
        end
        default: begin
          push_char(sym(b[7:2]), 1'b0);
          if (fin) begin
            push_char(sym({b[1:0], 4'h0}), 1'b0);
            push_char(CH_PAD, 1'b0);
            push_char(CH_PAD, 1'b1);
            phase = PH0;
            carry = 4'h0;
          end else begin
            carry = {2'b00, b[1:0]};
            phase = PH1;
          end
        end
      endcase
    endfunction

    function void check_char(logic [7:0] ch, logic last);
      enc_char_t e;
      if (expected_chars.size() == 0) begin
        $display("%0t: unexpected character: expected none, actual char %h last %b",
                 $time, ch, last);
        errors++;
        return;
      end
      e = expected_chars.pop_front();
      chars_checked++;
      if (ch !== e.ch) begin
        $display("%0t: out_char mismatch: expected %h, actual %h", $time, e.ch, ch);
        errors++;
      end
      if (last !== e.last) begin
        $display("%0t: out_last mismatch: expected %b, actual %b", $time, e.last, last);
        errors++;
      end
    endfunction

    function int pending();
      return expected_chars.size();
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst_n;
  logic       in_tvalid;
  logic       in_tready;
  logic [7:0] in_tdata;   // [7:0] data_byte
  logic       in_tlast;   // final_byte
  logic       out_tvalid;
  logic       out_tready;
  logic [7:0] out_tdata;  // [7:0] out_char
  logic       out_tlast;  // out_last

  b64_char_scoreboard encoded_chars = new();

  bit src_gaps;
  bit sink_stalls;
  int cycle_count;

  base64_stream_encoder i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  // Both handshakes are observed in one process, so a byte is always noted
  // before any character of the same edge is checked.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) encoded_chars.note_byte(in_tdata, in_tlast);
      if (out_tvalid && out_tready) encoded_chars.check_char(out_tdata, out_tlast);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d characters outstanding",
               cycle_count, encoded_chars.pending());
      $display("FAIL base64_stream_encoder");
      $finish;
    end
  end

  // Receiver: ready most of the time, with occasional stall bursts while sink_stalls is set.
  initial begin
    int stall_left;
    stall_left = 0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        out_tready <= 1'b0;
        stall_left--;
      end else if (sink_stalls && rst_n && $urandom_range(0, 4) == 0) begin
        out_tready <= 1'b0;
        stall_left = $urandom_range(1, 5) - 1;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after the byte
  // has been taken, with in_tvalid still high.
  task automatic send_byte(input logic [7:0] b, input logic fin);
    if (src_gaps && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= fin;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  // The last byte of every message carries the final flag.
  task automatic send_message(input logic [7:0] bytes[$]);
    foreach (bytes[i]) send_byte(bytes[i], i == bytes.size() - 1);
  endtask

  task automatic send_random_message(input int len);
    logic [7:0] bytes[$];
    repeat (len) bytes = {bytes, 8'($urandom_range(0, 255))};
    send_message(bytes);
  endtask

  initial begin
    int sent;
    int len;
    bit paused;
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = 8'h00;
    in_tlast    = 1'b0;
    src_gaps    = 1'b0;
    sink_stalls = 1'b0;
    cycle_count = 0;
    repeat (RESET_CYC) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed messages: a final byte in each group position, the all-zero
    // and all-one bytes, the two symbol characters, and top-bit-set bytes.
    send_message('{8'hFF});
    send_message('{8'h00});
    send_message('{8'hFF, 8'hFF});
    send_message('{8'h00, 8'h00, 8'h00});
    send_message('{8'hFB, 8'hFF, 8'hBF});
    sink_stalls = 1'b1;
    send_message('{8'h80, 8'h7F, 8'h01, 8'hFE});
    src_gaps = 1'b1;
    send_message('{8'hF8, 8'h3E, 8'h0F, 8'hC0, 8'hAA});
    send_message('{8'h55, 8'hAA, 8'h01, 8'h02, 8'h04, 8'h08});

    // Random messages, mostly short; gaps and stalls come and go per
    // message, and the tail of the run has none at all.
    sent   = 0;
    paused = 1'b0;
    while (sent < RANDOM_BYTES) begin
      if ($urandom_range(0, 7) == 0) len = $urandom_range(10, 24);
      else len = $urandom_range(1, 9);
      if (len > RANDOM_BYTES - sent) len = RANDOM_BYTES - sent;
      if (sent > RANDOM_BYTES - 30) begin
        src_gaps    = 1'b0;
        sink_stalls = 1'b0;
      end else begin
        src_gaps    = $urandom_range(0, 2) != 0;
        sink_stalls = $urandom_range(0, 2) != 0;
      end
      if (!paused && sent > RANDOM_BYTES / 2) begin
        // Let the encoder run dry before the next message.
        in_tvalid <= 1'b0;
        while (encoded_chars.pending() != 0) @(negedge clk);
        paused = 1'b1;
      end
      send_random_message(len);
      sent += len;
    end
    in_tvalid <= 1'b0;

    while (encoded_chars.pending() != 0) @(negedge clk);
    repeat (DRAIN_CYC) @(negedge clk);
    if (encoded_chars.pending() != 0) begin
      $display("%0d expected characters never arrived", encoded_chars.pending());
      encoded_chars.errors++;
    end

    $display("Encoded %0d bytes in %0d messages and checked %0d characters.",
             encoded_chars.bytes_seen, encoded_chars.messages_seen,
             encoded_chars.chars_checked);
    $display("Messages ended in every group position, under source gaps and output stalls.");
    if (encoded_chars.errors == 0) begin
      $display("PASS base64_stream_encoder");
    end else begin
      $display("FAIL base64_stream_encoder");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+rtl
rtl/b64s_pkg.sv
rtl/b64s_front.sv
rtl/b64s_queue.sv
rtl/b64s_back.sv
rtl/base64_stream_encoder.sv
test/base64_stream_encoder_tb.sv
